### rtl/rit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rit_pkg;

  localparam int TIME_BITS   = 32;
  localparam int REPEAT_BITS = 16;

  // Field widths of the request and result payloads
  localparam int KIND_W   = 2;
  localparam int FIELD_W  = 32;
  localparam int REPORT_W = 16;
  localparam int CFG_IDX_W = 2;

  typedef logic [TIME_BITS-1:0]   time_t;
  typedef logic [REPEAT_BITS-1:0] rep_t;

  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FORCE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOREVER  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] start_elapsed;
  } in_item_t;

  typedef struct packed {
    logic                expired_pulse;
    logic                is_running;
    logic                is_expired;
    logic [FIELD_W-1:0]  remaining_ms;
    logic [REPORT_W-1:0] repeats_left;
  } out_item_t;

  typedef struct packed {
    time_t interval;
    rep_t  repeat_target;
    logic  repeat_forever;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/rit_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module rit_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  input  wire logic [rit_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rit_pkg::FIELD_W-1:0]    cfg_data,
  output rit_pkg::cfg_t                       cfg
);

  rit_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interval       <= '0;
      cfg_r.repeat_target  <= '0;
      cfg_r.repeat_forever <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rit_pkg::REG_INTERVAL: cfg_r.interval <= rit_pkg::time_t'(cfg_data);
        rit_pkg::REG_TARGET:
          cfg_r.repeat_target <= rit_pkg::rep_t'(cfg_data[rit_pkg::REPORT_W-1:0]);
        rit_pkg::REG_FOREVER:  cfg_r.repeat_forever <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### rtl/rit_core.sv
`timescale 1ns / 1ps
`default_nettype none

module rit_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire rit_pkg::in_item_t  item,
  input  wire rit_pkg::cfg_t      cfg,
  output rit_pkg::out_item_t      result
);

  localparam logic [1:0] ST_STOPPED = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_EXPIRED = 2'd2;

  logic [1:0]     state_r, state_nxt;
  rit_pkg::time_t elapsed_r, elapsed_nxt;
  rit_pkg::rep_t  count_r, count_nxt;
  logic           force_r, force_nxt;

  rit_pkg::time_t elapsed_inc;
  rit_pkg::time_t remaining;
  logic           pulse;

  always_comb begin
    state_nxt   = state_r;
    elapsed_nxt = elapsed_r;
    count_nxt   = count_r;
    force_nxt   = force_r;
    pulse       = 1'b0;
    elapsed_inc = (elapsed_r != '1) ? rit_pkg::time_t'(elapsed_r + 1'b1) : elapsed_r;

    unique case (item.kind)
      rit_pkg::KIND_TICK: begin
        if (state_r == ST_EXPIRED && !cfg.repeat_forever && count_r == '0) begin
          state_nxt = ST_STOPPED;
        end else if (state_r != ST_STOPPED) begin
          state_nxt   = ST_RUNNING;
          elapsed_nxt = elapsed_inc;
          if (force_r || elapsed_inc >= cfg.interval) begin
            elapsed_nxt = '0;
            force_nxt   = 1'b0;
            state_nxt   = ST_EXPIRED;
            pulse       = 1'b1;
            if (!cfg.repeat_forever && count_r != '0)
              count_nxt = rit_pkg::rep_t'(count_r - 1'b1);
          end
        end
      end
      rit_pkg::KIND_START: begin
        state_nxt   = ST_RUNNING;
        elapsed_nxt = rit_pkg::time_t'(item.start_elapsed);
        count_nxt   = cfg.repeat_target;
        force_nxt   = 1'b0;
      end
      rit_pkg::KIND_STOP:  state_nxt = ST_STOPPED;
      rit_pkg::KIND_FORCE: force_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_STOPPED;
      elapsed_r <= '0;
      count_r   <= '0;
      force_r   <= 1'b0;
    end else if (step_en) begin
      state_r   <= state_nxt;
      elapsed_r <= elapsed_nxt;
      count_r   <= count_nxt;
      force_r   <= force_nxt;
    end
  end

  // Report is built from the post-update state
  always_comb begin
    if (force_nxt || elapsed_nxt >= cfg.interval)
      remaining = '0;
    else
      remaining = rit_pkg::time_t'(cfg.interval - elapsed_nxt);

    result.expired_pulse = pulse;
    result.is_running    = (state_nxt != ST_STOPPED);
    result.is_expired    = (state_nxt == ST_EXPIRED);
    result.remaining_ms  = (remaining > rit_pkg::time_t'(64'hFFFF_FFFF)) ?
                           '1 : rit_pkg::FIELD_W'(remaining);
    result.repeats_left  = (count_nxt > rit_pkg::rep_t'(32'hFFFF)) ?
                           '1 : rit_pkg::REPORT_W'(count_nxt);
  end

endmodule

`default_nettype wire

### rtl/repeating_interval_timer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake           | Payload
// in_     | in_valid / in_stall | in_data  (kind, start_elapsed)
// out_    | out_valid/ out_stall| out_data (pulse, flags, remaining_ms, repeats_left)
// cfg_    | cfg_valid/ cfg_ready| cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; a request passes through
// the input register, then the timer update into the result register.
// Synchronous active-low reset: timer stopped, config registers at defaults.
// A stalled result holds the result register; the input register keeps taking
// requests until it also fills, then in_stall rises.
module repeating_interval_timer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire rit_pkg::in_item_t             in_data,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output rit_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [rit_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rit_pkg::FIELD_W-1:0]   cfg_data
);

  rit_pkg::cfg_t      cfg;
  rit_pkg::in_item_t  in_r;
  logic               in_vld_r;
  rit_pkg::out_item_t out_r;
  rit_pkg::out_item_t step_result;
  logic               out_vld_r;
  logic               advance;

  assign cfg_ready = 1'b1;

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  rit_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rit_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_r),
    .cfg     (cfg),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall)
        in_vld_r <= in_valid;
      if (advance)
        out_vld_r <= 1'b1;
      else if (!out_stall)
        out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid)
      in_r <= in_data;
    if (advance)
      out_r <= step_result;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### tb/sv/tb_repeating_interval_timer.sv
`timescale 1ns / 1ps

module tb_repeating_interval_timer;

  localparam logic [rit_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int PHASES = 14;
  localparam int PHASE_REQS = 125;

  typedef enum logic [1:0] {TMR_STOPPED, TMR_RUNNING, TMR_EXPIRED} tmr_state_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  rit_pkg::in_item_t             in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  rit_pkg::out_item_t            out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [rit_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rit_pkg::FIELD_W-1:0]   cfg_data = '0;

  repeating_interval_timer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // timer model state and its copy of the registers
  tmr_state_t     tmr_state = TMR_STOPPED;
  rit_pkg::time_t tmr_elapsed = '0;
  rit_pkg::rep_t  tmr_reps = '0;
  logic           tmr_force = 1'b0;
  rit_pkg::time_t tmr_interval = '0;
  rit_pkg::rep_t  tmr_target = '0;
  logic           tmr_forever = 1'b1;

  rit_pkg::in_item_t  pending_reqs[$];
  rit_pkg::out_item_t due_results[$];
  int                 err_count = 0;
  int                 gap_left = 0;
  int                 stall_left = 0;
  bit                 in_no_gap = 1'b0;
  bit                 out_no_stall = 1'b0;
  rit_pkg::out_item_t want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic rit_pkg::out_item_t timer_step(input rit_pkg::in_item_t req);
    rit_pkg::out_item_t res;
    logic               pulse;
    logic               counting;
    rit_pkg::time_t     left;
    pulse = 1'b0;
    case (req.kind)
      rit_pkg::KIND_TICK: begin
        counting = (tmr_state != TMR_STOPPED);
        if (tmr_state == TMR_EXPIRED) begin
          if (tmr_forever || tmr_reps != '0) begin
            tmr_state = TMR_RUNNING;
          end else begin
            // last repeat done: this tick only stops the timer
            tmr_state = TMR_STOPPED;
            counting = 1'b0;
          end
        end
        if (counting) begin
          if (tmr_elapsed != '1) tmr_elapsed = tmr_elapsed + 1'b1;
          if (tmr_force || tmr_elapsed >= tmr_interval) begin
            tmr_elapsed = '0;
            tmr_force = 1'b0;
            tmr_state = TMR_EXPIRED;
            if (!tmr_forever && tmr_reps != '0) tmr_reps = tmr_reps - 1'b1;
            pulse = 1'b1;
          end
        end
      end
      rit_pkg::KIND_START: begin
        tmr_state = TMR_RUNNING;
        tmr_elapsed = req.start_elapsed;
        tmr_reps = tmr_target;
        tmr_force = 1'b0;
      end
      rit_pkg::KIND_STOP: begin
        tmr_state = TMR_STOPPED;
      end
      default: begin
        tmr_force = 1'b1;
      end
    endcase
    if (tmr_force || tmr_elapsed >= tmr_interval) left = '0;
    else left = tmr_interval - tmr_elapsed;
    res.expired_pulse = pulse;
    res.is_running = (tmr_state != TMR_STOPPED);
    res.is_expired = (tmr_state == TMR_EXPIRED);
    res.remaining_ms = left;
    res.repeats_left = tmr_reps;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(timer_step(in_data));
        gap_left = in_no_gap ? 0 : $urandom_range(0, 8);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_data));
        end else begin
          want = due_results.pop_front();
          if (out_data.expired_pulse !== want.expired_pulse)
            report_mismatch($sformatf("expired_pulse got %b want %b",
                                      out_data.expired_pulse, want.expired_pulse));
          if (out_data.is_running !== want.is_running)
            report_mismatch($sformatf("is_running got %b want %b",
                                      out_data.is_running, want.is_running));
          if (out_data.is_expired !== want.is_expired)
            report_mismatch($sformatf("is_expired got %b want %b",
                                      out_data.is_expired, want.is_expired));
          if (out_data.remaining_ms !== want.remaining_ms)
            report_mismatch($sformatf("remaining_ms got %h want %h",
                                      out_data.remaining_ms, want.remaining_ms));
          if (out_data.repeats_left !== want.repeats_left)
            report_mismatch($sformatf("repeats_left got %h want %h",
                                      out_data.repeats_left, want.repeats_left));
        end
        stall_left = out_no_stall ? 0 : $urandom_range(0, 8);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  task automatic push_req(input logic [rit_pkg::KIND_W-1:0] kind,
                          input logic [rit_pkg::FIELD_W-1:0] elapsed);
    rit_pkg::in_item_t req;
    req.kind = kind;
    req.start_elapsed = elapsed;
    pending_reqs.push_back(req);
  endtask

  // block until every queued request went in and every result came back;
  // checked mid-cycle so the driver's last update has settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || due_results.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [rit_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rit_pkg::FIELD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      rit_pkg::REG_INTERVAL: tmr_interval = val;
      rit_pkg::REG_TARGET:   tmr_target = val[rit_pkg::REPEAT_BITS-1:0];
      rit_pkg::REG_FOREVER:  tmr_forever = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [rit_pkg::FIELD_W-1:0] pick_interval();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic logic [rit_pkg::FIELD_W-1:0] pick_target();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'h0000_FFFF;
      2: return 32'd1;
      default: return $urandom_range(0, 4);
    endcase
  endfunction

  function automatic logic [rit_pkg::FIELD_W-1:0] pick_elapsed();
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  initial begin
    int pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: zero interval, repeat forever
    push_req(rit_pkg::KIND_TICK, 32'h0);
    push_req(rit_pkg::KIND_START, 32'h0);
    push_req(rit_pkg::KIND_TICK, 32'hFFFF_FFFF);
    push_req(rit_pkg::KIND_TICK, 32'h0);
    push_req(rit_pkg::KIND_STOP, 32'h0);
    push_req(rit_pkg::KIND_TICK, 32'h0);
    wait_idle();

    write_reg(rit_pkg::REG_INTERVAL, 32'd3);
    write_reg(rit_pkg::REG_TARGET, 32'd1);
    write_reg(REG_UNUSED, $urandom);
    write_reg(rit_pkg::REG_FOREVER, 32'd0);
    // saturated elapsed time, then stop after the last repeat
    push_req(rit_pkg::KIND_START, 32'hFFFF_FFFF);
    push_req(rit_pkg::KIND_TICK, 32'h0);
    push_req(rit_pkg::KIND_TICK, 32'h0);
    push_req(rit_pkg::KIND_TICK, 32'h0);
    // force while stopped, cleared by start; then a real forced expiry
    push_req(rit_pkg::KIND_FORCE, 32'h0);
    push_req(rit_pkg::KIND_TICK, 32'h0);
    push_req(rit_pkg::KIND_START, 32'd1);
    push_req(rit_pkg::KIND_TICK, 32'h0);
    push_req(rit_pkg::KIND_FORCE, 32'h0);
    push_req(rit_pkg::KIND_TICK, 32'h0);
    push_req(rit_pkg::KIND_TICK, 32'h0);
    wait_idle();

    write_reg(rit_pkg::REG_INTERVAL, 32'hFFFF_FFFF);
    write_reg(rit_pkg::REG_TARGET, 32'h0000_FFFF);
    push_req(rit_pkg::KIND_START, 32'h5555_5555);
    push_req(rit_pkg::KIND_TICK, 32'h0);
    push_req(rit_pkg::KIND_STOP, 32'h0);
    push_req(rit_pkg::KIND_TICK, 32'h0);
    push_req(rit_pkg::KIND_START, 32'hFFFF_FFFE);
    push_req(rit_pkg::KIND_TICK, 32'h0);
    push_req(rit_pkg::KIND_TICK, 32'h0);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      in_no_gap = ($urandom_range(0, 3) == 0);
      out_no_stall = ($urandom_range(0, 3) == 0);
      if (ph == 0) begin
        write_reg(rit_pkg::REG_INTERVAL, 32'h0);
        write_reg(rit_pkg::REG_TARGET, 32'h0);
        write_reg(rit_pkg::REG_FOREVER, 32'd0);
      end else if (ph == 1) begin
        write_reg(rit_pkg::REG_INTERVAL, 32'hFFFF_FFFF);
        write_reg(rit_pkg::REG_TARGET, 32'h0000_FFFF);
        write_reg(rit_pkg::REG_FOREVER, 32'd1);
      end else begin
        write_reg(rit_pkg::REG_INTERVAL, pick_interval());
        write_reg(rit_pkg::REG_TARGET, pick_target());
        write_reg(rit_pkg::REG_FOREVER, {$urandom} & 32'h1);
        if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
      end
      push_req(rit_pkg::KIND_START, pick_elapsed());
      for (int n = 1; n < PHASE_REQS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) push_req(rit_pkg::KIND_TICK, $urandom);
        else if (pick < 85) push_req(rit_pkg::KIND_START, pick_elapsed());
        else if (pick < 91) push_req(rit_pkg::KIND_STOP, $urandom);
        else push_req(rit_pkg::KIND_FORCE, $urandom);
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### repeating_interval_timer.f
rtl/rit_pkg.sv
rtl/rit_cfg.sv
rtl/rit_core.sv
rtl/repeating_interval_timer.sv
tb/sv/tb_repeating_interval_timer.sv
